// File: rtl/sau_pkg.sv
package sau_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;
  localparam int STEP_W    = $clog2(DATA_W);

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_MOD  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

endpackage

// File: rtl/sau_if.sv
interface sau_in_if;
  import sau_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] push_value;

  modport source(output valid, operation, push_value, input ready);
  modport sink(input valid, operation, push_value, output ready);
endinterface

interface sau_out_if;
  import sau_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic [CNT_OUT_W-1:0]     stack_count;
  logic [STAT_W-1:0]        status;

  modport source(output valid, top_value, stack_count, status, input ready);
  modport sink(input valid, top_value, stack_count, status, output ready);
endinterface

// File: rtl/stack_arithmetic_unit.sv
// Port      Dir  Handshake      Payload
// in_req    in   valid/ready    operation, push_value
// out_rsp   out  valid/ready    top_value, stack_count, status
//
// Push, add, sub, error and unused codes go from S_LOAD to S_DONE and the output register.
// Mul runs the 32-step loop in S_ITER over one shared adder; div and mod then fix signs in S_FIX.
// One request at a time; in_req.ready is high only while the sequencer idles.
// A finished result waits in the output register; a completed request stalls
// in its last step until that register frees. Synchronous active-low reset
// empties the stack; stack memory contents are not cleared.
module stack_arithmetic_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  sau_in_if.sink   in_req,
  sau_out_if.source out_rsp
);
  import sau_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = DATA_W + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_ITER = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [DATA_W-1:0]    pv_r, pv_nxt;
  logic [DATA_W-1:0]    top_r, top_nxt;
  logic [DATA_W-1:0]    rd_data_r;
  logic [DATA_W-1:0]    acc_r, acc_nxt;
  logic [DATA_W-1:0]    opa_r, opa_nxt;
  logic [DATA_W-1:0]    opb_r, opb_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 qneg_r, qneg_nxt;
  logic                 rneg_r, rneg_nxt;
  logic [DATA_W-1:0]    res_r, res_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [DATA_W-1:0]    out_top_r, out_top_nxt;
  logic [CNT_OUT_W-1:0] out_count_r, out_count_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;

  logic [DATA_W-1:0]    stack_mem [STACK_DEPTH];
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [DATA_W-1:0]    mem_wdata;

  logic [SW-1:0]        alu_a, alu_b, alu_sum;
  logic                 alu_sub;

  logic                 accept;
  logic                 out_free;
  logic                 is_arith;
  logic [DATA_W-1:0]    fix_val;
  logic [DATA_W-1:0]    mul_acc;
  logic [DATA_W-1:0]    s_mag, t_mag;

  assign accept    = in_req.valid && in_req.ready;
  assign out_free  = !out_valid_r || out_rsp.ready;
  assign is_arith  = op_r inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD};
  assign rd_addr   = AW'(count_r - CW'(2));
  assign fix_val   = (op_r == OP_DIV) ? opa_r : acc_r;
  assign mul_acc   = opb_r[0] ? alu_sum[DATA_W-1:0] : acc_r;
  assign s_mag     = rd_data_r[DATA_W-1] ? (~rd_data_r + DATA_W'(1)) : rd_data_r;
  assign t_mag     = top_r[DATA_W-1] ? (~top_r + DATA_W'(1)) : top_r;

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.top_value   = out_top_r;
  assign out_rsp.stack_count = out_count_r;
  assign out_rsp.status      = out_status_r;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_LOAD: begin
        alu_a   = {2'b00, rd_data_r};
        alu_b   = {2'b00, top_r};
        alu_sub = (op_r == OP_SUB);
      end
      S_ITER: begin
        if (op_r == OP_MUL) begin
          alu_a = {2'b00, acc_r};
          alu_b = {2'b00, opa_r};
        end else begin
          alu_a   = {1'b0, acc_r, opa_r[DATA_W-1]};
          alu_b   = {2'b00, opb_r};
          alu_sub = 1'b1;
        end
      end
      S_FIX: begin
        alu_b   = {2'b00, fix_val};
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + SW'(alu_sub);
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    pv_nxt         = pv_r;
    top_nxt        = top_r;
    acc_nxt        = acc_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    step_nxt       = step_r;
    qneg_nxt       = qneg_r;
    rneg_nxt       = rneg_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    out_top_nxt    = out_top_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = pv_r;

    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_req.operation;
          pv_nxt    = in_req.push_value;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
        if (op_r == OP_PUSH) begin
          if (count_r == CW'(STACK_DEPTH)) begin
            status_nxt = ST_FULL;
          end
        end else if (is_arith) begin
          if (count_r < CW'(2)) begin
            status_nxt = ST_SHORT;
          end else if ((op_r == OP_DIV || op_r == OP_MOD) && top_r == '0) begin
            status_nxt = ST_DIVZERO;
          end else begin
            case (op_r)
              OP_ADD, OP_SUB: begin
                res_nxt = alu_sum[DATA_W-1:0];
              end
              OP_MUL: begin
                acc_nxt   = '0;
                opa_nxt   = rd_data_r;
                opb_nxt   = top_r;
                step_nxt  = '0;
                state_nxt = S_ITER;
              end
              default: begin
                acc_nxt   = '0;
                opa_nxt   = s_mag;
                opb_nxt   = t_mag;
                qneg_nxt  = rd_data_r[DATA_W-1] ^ top_r[DATA_W-1];
                rneg_nxt  = rd_data_r[DATA_W-1];
                step_nxt  = '0;
                state_nxt = S_ITER;
              end
            endcase
          end
        end
      end
      S_ITER: begin
        step_nxt = step_r + STEP_W'(1);
        if (op_r == OP_MUL) begin
          acc_nxt = mul_acc;
          opa_nxt = {opa_r[DATA_W-2:0], 1'b0};
          opb_nxt = {1'b0, opb_r[DATA_W-1:1]};
        end else begin
          acc_nxt = alu_sum[SW-1] ? {acc_r[DATA_W-2:0], opa_r[DATA_W-1]}
                                  : alu_sum[DATA_W-1:0];
          opa_nxt = {opa_r[DATA_W-2:0], !alu_sum[SW-1]};
        end
        if (step_r == STEP_W'(DATA_W - 1)) begin
          if (op_r == OP_MUL) begin
            res_nxt   = mul_acc;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FIX;
          end
        end
      end
      S_FIX: begin
        if ((op_r == OP_DIV) ? qneg_r : rneg_r) begin
          res_nxt = alu_sum[DATA_W-1:0];
        end else begin
          res_nxt = fix_val;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          if (status_r == ST_OK && op_r == OP_PUSH) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[AW-1:0];
            mem_wdata = pv_r;
            count_nxt = count_r + CW'(1);
            top_nxt   = pv_r;
          end else if (status_r == ST_OK && is_arith) begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr;
            mem_wdata = res_r;
            count_nxt = count_r - CW'(1);
            top_nxt   = res_r;
          end else if (status_r == ST_SHORT || status_r == ST_DIVZERO) begin
            count_nxt = '0;
          end
          out_top_nxt    = (count_nxt == '0) ? '0 : top_nxt;
          out_count_nxt  = CNT_OUT_W'(count_nxt);
          out_status_nxt = status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pv_r         <= pv_nxt;
    top_r        <= top_nxt;
    acc_r        <= acc_nxt;
    opa_r        <= opa_nxt;
    opb_r        <= opb_nxt;
    step_r       <= step_nxt;
    qneg_r       <= qneg_nxt;
    rneg_r       <= rneg_nxt;
    res_r        <= res_nxt;
    status_r     <= status_nxt;
    out_top_r    <= out_top_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= stack_mem[rd_addr];
    end
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
  end

endmodule
